// ===== rtl/pid_pkg.sv =====
`default_nettype none

package pid_pkg;

    // Number format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DT_WIDTH   = 16;

    // Packed stream widths
    localparam int IN_W  = DATA_WIDTH + DT_WIDTH;
    localparam int OUT_W = DATA_WIDTH;

    // Configuration port
    localparam int CAP_W     = DATA_WIDTH - 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CAP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_CAP   = 3'd5;

    // Divider: dividend is |change| with DT_WIDTH zero bits appended, two bits per cycle
    localparam int DIV_W     = DATA_WIDTH + DT_WIDTH;
    localparam int DIV_ITERS = DIV_W / 2;
    localparam int CNT_W     = $clog2(DIV_ITERS);

    // Datapath commands
    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [OP_W-1:0] OP_ERR    = 4'd2;
    localparam logic [OP_W-1:0] OP_PREP   = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd4;
    localparam logic [OP_W-1:0] OP_INTEG  = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_I  = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL_D  = 4'd7;
    localparam logic [OP_W-1:0] OP_TERM_D = 4'd8;
    localparam logic [OP_W-1:0] OP_SUM    = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } pid_cmd_t;

    typedef struct packed {
        logic out_free;   // output register empty or being taken this cycle
    } pid_sts_t;

endpackage

`default_nettype wire

// ===== rtl/pid_ctrl.sv =====
`default_nettype none

module pid_ctrl
    import pid_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire pid_sts_t sts,
    output pid_cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ERR    = 4'd1;
    localparam logic [3:0] ST_PREP   = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_INTEG  = 4'd4;
    localparam logic [3:0] ST_MUL_I  = 4'd5;
    localparam logic [3:0] ST_MUL_D  = 4'd6;
    localparam logic [3:0] ST_TERM_D = 4'd7;
    localparam logic [3:0] ST_SUM    = 4'd8;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_ITERS - 1);

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [CNT_W-1:0] div_cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd.op       = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.op       = OP_PREP;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op       = OP_DIV;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                cmd.op     = OP_INTEG;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.op     = OP_MUL_I;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.op     = OP_MUL_D;
                state_next = ST_TERM_D;
            end
            ST_TERM_D:
            begin
                cmd.op     = OP_TERM_D;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // wait for room in the output register
                if (sts.out_free)
                begin
                    cmd.op     = OP_SUM;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // An accepted transaction always starts the error step
    a_accept_to_err: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_ERR))
        else $error("accepted item did not start processing");

    // The divider runs exactly DIV_ITERS iterations before the integral step
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |-> ##DIV_ITERS (state_reg == ST_DIV) ##1 (state_reg == ST_INTEG))
        else $error("divider iteration count wrong");

endmodule

`default_nettype wire

// ===== rtl/pid_dp.sv =====
`default_nettype none

module pid_dp
    import pid_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pid_cmd_t             cmd,
    output pid_sts_t                  sts,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_WIDTH-1:0] cfg_data,
    input  wire logic [IN_W-1:0]      s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata,
    output logic                      m_tuser
);

    localparam int SAT_W  = 2 * DATA_WIDTH + 2;
    localparam int PROD_W = 2 * DATA_WIDTH + 1;
    localparam logic [DIV_W-1:0] DIV_LIM = DIV_W'(1) << (DATA_WIDTH - 1);
    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    // Saturate a wide signed value to DATA_WIDTH bits
    function automatic logic signed [DATA_WIDTH-1:0] sat_val(input logic signed [SAT_W-1:0] x);
        logic [SAT_W-DATA_WIDTH:0] top;
        top = x[SAT_W-1:DATA_WIDTH-1];
        if (top == '0 || top == '1)
        begin
            return x[DATA_WIDTH-1:0];
        end
        else if (x[SAT_W-1])
        begin
            return VAL_MIN;
        end
        return VAL_MAX;
    endfunction

    // Symmetric clamp; returns {hit, value}
    function automatic logic [DATA_WIDTH:0] clamp_sym(input logic signed [DATA_WIDTH-1:0] x,
                                                       input logic [CAP_W-1:0] cap);
        logic signed [DATA_WIDTH:0] cap_s;
        logic signed [DATA_WIDTH:0] ncap_s;
        logic signed [DATA_WIDTH:0] x_s;
        cap_s  = $signed({2'b00, cap});
        ncap_s = -cap_s;
        x_s    = (DATA_WIDTH + 1)'(x);
        if (x_s > cap_s)
        begin
            return {1'b1, cap_s[DATA_WIDTH-1:0]};
        end
        else if (x_s < ncap_s)
        begin
            return {1'b1, ncap_s[DATA_WIDTH-1:0]};
        end
        return {1'b0, x};
    endfunction

    // Configuration
    logic signed [DATA_WIDTH-1:0] target_reg, target_next;
    logic signed [DATA_WIDTH-1:0] gain_p_reg, gain_p_next;
    logic signed [DATA_WIDTH-1:0] gain_i_reg, gain_i_next;
    logic signed [DATA_WIDTH-1:0] gain_d_reg, gain_d_next;
    logic [CAP_W-1:0]             drive_cap_reg, drive_cap_next;
    logic [CAP_W-1:0]             sum_cap_reg, sum_cap_next;

    // Controller state
    logic signed [DATA_WIDTH-1:0] sum_reg, sum_next;
    logic signed [DATA_WIDTH-1:0] prev_err_reg, prev_err_next;
    logic                         out_valid_reg, out_valid_next;

    // Working registers
    logic signed [DATA_WIDTH-1:0] meas_reg, meas_next;
    logic [DT_WIDTH-1:0]          dt_reg, dt_next;
    logic signed [DATA_WIDTH-1:0] err_reg, err_next;
    logic                         neg_reg, neg_next;
    logic [DIV_W-1:0]             quo_reg, quo_next;
    logic [DT_WIDTH-1:0]          rem_reg, rem_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [DATA_WIDTH-1:0] deriv_reg, deriv_next;
    logic signed [DATA_WIDTH-1:0] term_p_reg, term_p_next;
    logic signed [DATA_WIDTH-1:0] term_i_reg, term_i_next;
    logic signed [DATA_WIDTH-1:0] term_d_reg, term_d_next;
    logic signed [DATA_WIDTH-1:0] drive_reg, drive_next;
    logic                         clamped_reg, clamped_next;

    // Combinational helpers
    logic signed [DATA_WIDTH:0]   mul_a;
    logic signed [DATA_WIDTH-1:0] mul_b;
    logic signed [DATA_WIDTH-1:0] change;
    logic [DATA_WIDTH-1:0]        change_mag;
    logic [DT_WIDTH:0]            div_r1;
    logic [DT_WIDTH:0]            div_r2;
    logic [DT_WIDTH-1:0]          div_rem1;
    logic                         div_b1;
    logic                         div_b2;
    logic signed [DATA_WIDTH-1:0] gain_scaled;
    logic signed [DATA_WIDTH-1:0] inc;
    logic signed [DATA_WIDTH-1:0] sum_sat;
    logic signed [DATA_WIDTH-1:0] acc_sat;
    logic [DATA_WIDTH:0]          sum_clamp;
    logic [DATA_WIDTH:0]          acc_clamp;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = (DATA_WIDTH + 1)'(gain_p_reg);
        mul_b = err_reg;
        case (cmd.op)
            OP_PREP:
            begin
                mul_a = $signed({{(DATA_WIDTH + 1 - DT_WIDTH){1'b0}}, dt_reg});
                mul_b = err_reg;
            end
            OP_INTEG:
            begin
                mul_a = (DATA_WIDTH + 1)'(gain_p_reg);
                mul_b = err_reg;
            end
            OP_MUL_I:
            begin
                mul_a = (DATA_WIDTH + 1)'(gain_i_reg);
                mul_b = sum_reg;
            end
            OP_MUL_D:
            begin
                mul_a = (DATA_WIDTH + 1)'(gain_d_reg);
                mul_b = deriv_reg;
            end
            default:
            begin
                mul_a = (DATA_WIDTH + 1)'(gain_p_reg);
                mul_b = err_reg;
            end
        endcase
    end

    // Error change and its magnitude for the divider
    assign change     = sat_val(SAT_W'(err_reg) - SAT_W'(prev_err_reg));
    assign change_mag = change[DATA_WIDTH-1] ? DATA_WIDTH'(~change + 1'b1) : change;

    // Two restoring division steps
    always_comb
    begin
        div_r1 = {rem_reg, quo_reg[DIV_W-1]};
        div_b1 = (div_r1 >= {1'b0, dt_reg});
        if (div_b1)
        begin
            div_r1 = div_r1 - {1'b0, dt_reg};
        end
        div_rem1 = div_r1[DT_WIDTH-1:0];
        div_r2   = {div_rem1, quo_reg[DIV_W-2]};
        div_b2   = (div_r2 >= {1'b0, dt_reg});
        if (div_b2)
        begin
            div_r2 = div_r2 - {1'b0, dt_reg};
        end
    end

    // Product post-processing
    assign gain_scaled = sat_val(SAT_W'(prod_reg >>> FRAC_BITS));
    assign inc         = sat_val(SAT_W'(prod_reg >>> DT_WIDTH));
    assign sum_sat     = sat_val(SAT_W'(sum_reg) + SAT_W'(inc));
    assign sum_clamp   = clamp_sym(sum_sat, sum_cap_reg);
    assign acc_sat     = sat_val(SAT_W'(term_p_reg) + SAT_W'(term_i_reg) + SAT_W'(term_d_reg));
    assign acc_clamp   = clamp_sym(acc_sat, drive_cap_reg);

    // Next-state logic
    always_comb
    begin
        target_next    = target_reg;
        gain_p_next    = gain_p_reg;
        gain_i_next    = gain_i_reg;
        gain_d_next    = gain_d_reg;
        drive_cap_next = drive_cap_reg;
        sum_cap_next   = sum_cap_reg;
        sum_next       = sum_reg;
        prev_err_next  = prev_err_reg;
        out_valid_next = out_valid_reg;
        meas_next      = meas_reg;
        dt_next        = dt_reg;
        err_next       = err_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        prod_next      = prod_reg;
        deriv_next     = deriv_reg;
        term_p_next    = term_p_reg;
        term_i_next    = term_i_reg;
        term_d_next    = term_d_reg;
        drive_next     = drive_reg;
        clamped_next   = clamped_reg;

        // result taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // register writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET:
                begin
                    target_next = cfg_data;
                    sum_next    = '0;
                end
                REG_GAIN_P:    gain_p_next    = cfg_data;
                REG_GAIN_I:    gain_i_next    = cfg_data;
                REG_GAIN_D:    gain_d_next    = cfg_data;
                REG_DRIVE_CAP: drive_cap_next = cfg_data[CAP_W-1:0];
                REG_SUM_CAP:   sum_cap_next   = cfg_data[CAP_W-1:0];
                default:
                begin
                end
            endcase
        end

        case (cmd.op)
            OP_LOAD:
            begin
                meas_next = s_tdata[DATA_WIDTH-1:0];
                dt_next   = s_tdata[IN_W-1:DATA_WIDTH];
            end
            OP_ERR:
            begin
                err_next = sat_val(SAT_W'(target_reg) - SAT_W'(meas_reg));
            end
            OP_PREP:
            begin
                neg_next  = change[DATA_WIDTH-1];
                quo_next  = {change_mag, {DT_WIDTH{1'b0}}};
                rem_next  = '0;
                prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            OP_DIV:
            begin
                quo_next = {quo_reg[DIV_W-3:0], div_b1, div_b2};
                rem_next = div_r2[DT_WIDTH-1:0];
            end
            OP_INTEG:
            begin
                // finish derivative, update integral, start proportional product
                if (dt_reg == '0)
                begin
                    deriv_next = '0;
                end
                else if (neg_reg)
                begin
                    if (quo_reg > DIV_LIM)
                    begin
                        deriv_next = VAL_MIN;
                    end
                    else
                    begin
                        deriv_next = DATA_WIDTH'(~quo_reg[DATA_WIDTH-1:0] + 1'b1);
                    end
                end
                else if (quo_reg >= DIV_LIM)
                begin
                    deriv_next = VAL_MAX;
                end
                else
                begin
                    deriv_next = quo_reg[DATA_WIDTH-1:0];
                end
                sum_next  = sum_clamp[DATA_WIDTH-1:0];
                prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            OP_MUL_I:
            begin
                term_p_next = gain_scaled;
                prod_next   = PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            OP_MUL_D:
            begin
                term_i_next = gain_scaled;
                prod_next   = PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            OP_TERM_D:
            begin
                term_d_next = gain_scaled;
            end
            OP_SUM:
            begin
                drive_next     = acc_clamp[DATA_WIDTH-1:0];
                clamped_next   = acc_clamp[DATA_WIDTH];
                out_valid_next = 1'b1;
                prev_err_next  = err_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            drive_cap_reg <= '0;
            sum_cap_reg   <= '0;
            sum_reg       <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
            drive_cap_reg <= drive_cap_next;
            sum_cap_reg   <= sum_cap_next;
            sum_reg       <= sum_next;
            prev_err_reg  <= prev_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        meas_reg    <= meas_next;
        dt_reg      <= dt_next;
        err_reg     <= err_next;
        neg_reg     <= neg_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        prod_reg    <= prod_next;
        deriv_reg   <= deriv_next;
        term_p_reg  <= term_p_next;
        term_i_reg  <= term_i_next;
        term_d_reg  <= term_d_next;
        drive_reg   <= drive_next;
        clamped_reg <= clamped_next;
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = drive_reg;
    assign m_tuser      = clamped_reg;

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SUM) |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before transaction");

    // The integral lies within its cap right after an update
    a_sum_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_INTEG && !cfg_we) |=>
        (((DATA_WIDTH + 1)'(sum_reg) <= $signed({2'b00, sum_cap_reg}))
        && ((DATA_WIDTH + 1)'(sum_reg) >= -$signed({2'b00, sum_cap_reg}))))
        else $error("integral outside its cap");

endmodule

`default_nettype wire

// ===== rtl/pid_controller.sv =====
`default_nettype none

// Channel   Direction  Signals                       Contents (low bits first)
// s_axis    in         s_tvalid s_tready s_tdata     measured[31:0], step_time[47:32]
// m_axis    out        m_tvalid m_tready m_tdata     drive[31:0]; m_tuser = drive_clamped
// cfg       in         cfg_we cfg_index cfg_data     0 target .. 5 sum_cap, one write per cycle
//
// An item runs through the error, prep, division, integral, gain product and sum
// steps before its result is valid, and the next item is accepted only once the
// sequencer is idle again; the 48-bit derivative division at two quotient bits
// per cycle takes most of that time. The shared 33x32 multiplier forms the integral
// product ahead of the division and the three gain products after it.
// Input is taken only while the sequencer is idle; a new item may enter while
// the previous result still waits in the output register, and the sequencer
// holds its final step until that register is free.
// Reset (rst_n, asynchronous) clears the sequencer, the configuration registers,
// the integral, the last error and the output valid; working registers load before use.

module pid_controller
    import pid_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,   // measured, step_time
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata,   // drive
    output logic                       m_tuser,   // drive_clamped
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_WIDTH-1:0] cfg_data
);

    pid_cmd_t cmd;
    pid_sts_t sts;

    pid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pid_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pid_pkg::*;

    localparam int TIMEOUT_CYCLES = 600_000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_SAMPLES  = 125;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;

    // s_tdata layout: measured in the low bits, step_time above it
    typedef struct packed {
        logic [DT_WIDTH-1:0]          step_time;
        logic signed [DATA_WIDTH-1:0] measured;
    } sample_t;

    typedef struct packed {
        logic                  drive_clamped;
        logic [DATA_WIDTH-1:0] drive;
    } drive_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;   // measured, step_time
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;          // drive
    logic                  m_tuser;          // drive_clamped
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_WIDTH-1:0] cfg_data  = '0;

    pid_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Controller shadow: registers and loop state
    longint set_point, kp, ki, kd, drive_limit, integ_limit;
    longint integ_acc, prior_error;

    sample_t       pending_samples[$];
    drive_result_t drive_expect[$];
    drive_result_t got, want;

    bit in_taken;
    int mismatches;
    int send_idle, recv_idle;     // percent of cycles each side idles
    int hold_requests, hold_served, hold_left;
    int cycle_count;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint sat32(longint x);
        if (x > VAL_MAX)
            return VAL_MAX;
        if (x < VAL_MIN)
            return VAL_MIN;
        return x;
    endfunction

    // Q16.16 gain times value, floored, saturated
    function automatic longint gain_term(longint g, longint x);
        return sat32((g * x) >>> FRAC_BITS);
    endfunction

    // One loop iteration: updates the integral and last error, returns the drive
    function automatic drive_result_t predict_drive(sample_t smp);
        longint meas, dt, err, chg, deriv, acc;
        drive_result_t res;
        meas  = longint'(signed'(smp.measured));
        dt    = longint'(smp.step_time);
        err   = sat32(set_point - meas);
        deriv = 0;
        if (dt != 0)
        begin
            chg   = sat32(err - prior_error);
            deriv = sat32((chg * (longint'(1) << DT_WIDTH)) / dt);
        end
        integ_acc = sat32(integ_acc + ((err * dt) >>> DT_WIDTH));
        if (integ_acc > integ_limit)
            integ_acc = integ_limit;
        else if (integ_acc < -integ_limit)
            integ_acc = -integ_limit;
        acc = sat32(gain_term(kp, err) + gain_term(ki, integ_acc) + gain_term(kd, deriv));
        res.drive_clamped = 1'b0;
        if (acc > drive_limit)
        begin
            acc = drive_limit;
            res.drive_clamped = 1'b1;
        end
        else if (acc < -drive_limit)
        begin
            acc = -drive_limit;
            res.drive_clamped = 1'b1;
        end
        res.drive   = acc[DATA_WIDTH-1:0];
        prior_error = err;
        return res;
    endfunction

    // Mostly moderate gains/setpoints, sometimes the extremes or any pattern
    function automatic logic [DATA_WIDTH-1:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $urandom_range(2 ** 18) - 2 ** 17;
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_cap();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;   // bit 31 must be dropped by the block
            default: return $urandom_range(1, 2 ** 24);
        endcase
    endfunction

    // Register write, shadow updated alongside; the bus stays busy until end_cfg
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_TARGET:
            begin
                set_point = longint'(signed'(data));
                integ_acc = 0;
            end
            REG_GAIN_P:    kp          = longint'(signed'(data));
            REG_GAIN_I:    ki          = longint'(signed'(data));
            REG_GAIN_D:    kd          = longint'(signed'(data));
            REG_DRIVE_CAP: drive_limit = longint'(data[CAP_W-1:0]);
            REG_SUM_CAP:   integ_limit = longint'(data[CAP_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic end_cfg();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_sample(input longint meas, input int dt);
        sample_t smp;
        smp.measured  = meas[DATA_WIDTH-1:0];
        smp.step_time = dt[DT_WIDTH-1:0];
        pending_samples.push_back(smp);
    endtask

    // Sender pauses until every queued sample is taken and every drive is back;
    // polled at the rising edge, where the offer and the queues are settled
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_tvalid || drive_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                send_idle = 10;
                recv_idle = 56;
            end
            1:
            begin
                send_idle = 56;
                recv_idle = 10;
            end
            default:
            begin
                send_idle = 0;
                recv_idle = 0;
            end
        endcase
    endtask

    // Sample driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_samples.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Drive receiver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Monitor: check drives, then predict for a newly taken sample
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken = s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got.drive         = m_tdata;
                got.drive_clamped = m_tuser;
                if (drive_expect.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected drive transaction: drive %h clamped %b",
                                 got.drive, got.drive_clamped);
                end
                else
                begin
                    want = drive_expect.pop_front();
                    if (got.drive !== want.drive || got.drive_clamped !== want.drive_clamped)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("drive mismatch: drive exp %h got %h, clamped exp %b got %b",
                                     want.drive, got.drive, want.drive_clamped,
                                     got.drive_clamped);
                    end
                end
            end
            if (in_taken)
                drive_expect.push_back(predict_drive(s_tdata));
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        int     phase;
        int     dt;
        longint meas;

        set_point   = 0;
        kp          = 0;
        ki          = 0;
        kd          = 0;
        drive_limit = 0;
        integ_limit = 0;
        integ_acc   = 0;
        prior_error = 0;
        set_idle(0);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Nominal gains, widest caps: field extremes, zero and full time step
        write_reg(REG_TARGET, 32'h0001_0000);
        write_reg(REG_GAIN_P, 32'h0001_0000);
        write_reg(REG_GAIN_I, 32'h0000_8000);
        write_reg(REG_GAIN_D, 32'h0000_4000);
        write_reg(REG_DRIVE_CAP, 32'h7FFF_FFFF);
        write_reg(REG_SUM_CAP, 32'h7FFF_FFFF);
        end_cfg();
        add_sample(0, 0);
        add_sample(0, 16'hFFFF);
        add_sample(VAL_MAX, 16'h8000);
        add_sample(VAL_MIN, 1);
        add_sample(VAL_MIN, 16'hFFFF);
        add_sample(32'sh0001_0000, 16'h0100);
        add_sample(VAL_MAX, 0);
        add_sample(-64'sh0001_0000, 16'h4000);
        wait_drained();

        // Extreme gains and setpoint, tight caps
        write_reg(REG_TARGET, 32'h8000_0000);
        write_reg(REG_GAIN_P, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_I, 32'h8000_0000);
        write_reg(REG_GAIN_D, 32'h7FFF_FFFF);
        write_reg(REG_DRIVE_CAP, 32'h0005_0000);
        write_reg(REG_SUM_CAP, 32'h0002_0000);
        end_cfg();
        add_sample(VAL_MAX, 16'hFFFF);
        add_sample(VAL_MIN, 16'h0001);
        add_sample(0, 0);
        add_sample(-64'sh0000_0001, 16'h7FFF);
        add_sample(64'sh1234_5678, 16'h0010);
        add_sample(VAL_MIN, 0);
        wait_drained();

        // Zero caps: integral and drive forced to zero; last pair gives a zero sum
        write_reg(REG_GAIN_P, 32'h0001_0000);
        write_reg(REG_GAIN_I, 32'h0001_0000);
        write_reg(REG_GAIN_D, 32'h0001_0000);
        write_reg(REG_DRIVE_CAP, 32'h0000_0000);
        write_reg(REG_SUM_CAP, 32'h8000_0000);
        write_reg(REG_TARGET, 32'h0003_0000);
        end_cfg();
        add_sample(0, 16'h2000);
        add_sample(64'sh0003_0000, 16'h0100);
        add_sample(64'sh0003_0000, 16'h0100);
        add_sample(64'sh0003_0000, 0);
        wait_drained();

        // New setpoint clears the integral but keeps the last error; spare indexes ignored
        write_reg(REG_SUM_CAP, 32'h7FFF_FFFF);
        write_reg(REG_DRIVE_CAP, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_6, 32'hDEAD_BEEF);
        write_reg(REG_SPARE_7, 32'h1234_5678);
        write_reg(REG_TARGET, 32'hFFFE_0000);
        end_cfg();
        add_sample(64'sh0001_0000, 16'h1000);
        add_sample(64'sh0001_0000, 16'h1000);
        add_sample(-64'sh0002_0000, 16'h0800);
        wait_drained();

        // Random phases: first both sides idle, then swapped, then none
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_idle(phase * 3 / RANDOM_PHASES);
            if (phase == 0 || $urandom_range(1) == 1)
                write_reg(REG_TARGET, rand_word());
            write_reg(REG_GAIN_P, rand_word());
            write_reg(REG_GAIN_I, rand_word());
            write_reg(REG_GAIN_D, rand_word());
            write_reg(REG_DRIVE_CAP, rand_cap());
            write_reg(REG_SUM_CAP, rand_cap());
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
            end_cfg();

            for (int k = 0; k < PHASE_SAMPLES; k++)
            begin
                case ($urandom_range(9))
                    0: meas = longint'(signed'(32'($urandom)));
                    1:
                    begin
                        case ($urandom_range(2))
                            0: meas = VAL_MAX;
                            1: meas = VAL_MIN;
                            default: meas = 0;
                        endcase
                    end
                    // near the setpoint, so the loop does not just saturate
                    default: meas = sat32(set_point + longint'($urandom_range(2 ** 21))
                                          - 2 ** 20);
                endcase
                case ($urandom_range(19))
                    0, 1: dt = 0;
                    2: dt = 16'hFFFF;
                    3: dt = 1;
                    4, 5, 6: dt = $urandom_range(16'hFFFF);
                    default: dt = $urandom_range(1, 16'h1000);
                endcase
                add_sample(meas, dt);
            end

            // Long receiver hold-off while samples keep coming
            if (phase == RANDOM_PHASES - 3)
                hold_requests++;
            wait_drained();
        end

        repeat (40) @(negedge clk);
        if (mismatches == 0 && drive_expect.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
